/* design/gpio_port_register_block_defines.svh */
// Assertion macros shared by the port register block.
// Each macro checks a property on the rising clock edge while reset is released.
`ifndef GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH

`ifndef ASSERT_OFF
`define GPRB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gprb assertion failed");
`define GPRB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gprb implication failed");
`define GPRB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gprb next-cycle check failed");
`else
`define GPRB_ASSERT(name, clk, rst_n, prop)
`define GPRB_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define GPRB_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* design/gprb_pkg.sv */
`default_nettype none

package gprb_pkg;

  // Register offsets of the port.
  typedef enum logic [3:0] {
    REG_MODE     = 4'd0,
    REG_TYPE     = 4'd1,
    REG_SPEED    = 4'd2,
    REG_PULL     = 4'd3,
    REG_INPUT    = 4'd4,
    REG_OUTPUT   = 4'd5,
    REG_SETRESET = 4'd6,
    REG_LOCK     = 4'd7,
    REG_AFLOW    = 4'd8,
    REG_AFHIGH   = 4'd9
  } reg_idx_e;

  // Bus access kind.
  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  // Bit position of the lock key in the lock register.
  localparam int unsigned LockKeyBit = 16;

  // One bus transaction.
  typedef struct packed {
    logic        action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic        lock_active;
    logic        write_blocked;
  } rsp_t;

  // Command from the register logic to the lock sequencer.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic        key;
    logic [15:0] mask;
  } lock_cmd_t;

  // Lock sequencer status.
  typedef struct packed {
    logic [15:0] mask;
    logic        locked;
    logic        locked_next;
  } lock_stat_t;

  // Widen a per-pin mask to the 2-bit fields of each pin.
  function automatic logic [31:0] spread2(logic [15:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{pins[i]}};
    end
    return r;
  endfunction

  // Widen an 8-pin mask to the 4-bit alternate-function fields.
  function automatic logic [31:0] spread4(logic [7:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{pins[i]}};
    end
    return r;
  endfunction

  // New register value: implemented, unlocked bits take the write data.
  function automatic logic [31:0] guarded_write(logic [31:0] cur, logic [31:0] data,
                                                logic [31:0] impl, logic [31:0] locked);
    logic [31:0] writable;
    writable = impl & ~locked;
    return (cur & ~writable) | (data & writable);
  endfunction

  // True when the write tries to change a bit of a locked pin.
  function automatic logic guarded_hit(logic [31:0] cur, logic [31:0] data,
                                       logic [31:0] impl, logic [31:0] locked);
    return |((cur ^ data) & impl & locked);
  endfunction

endpackage

`default_nettype wire

/* design/gprb_lock.sv */
`default_nettype none

// Lock key sequencer: write key 1, key 0, key 1 with one mask, then read.
module gprb_lock
  import gprb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lock_cmd_t  cmd_i,
  output lock_stat_t      stat_o
);

  typedef enum logic [4:0] {
    LK_IDLE   = 5'b00001,
    LK_KEY1   = 5'b00010,
    LK_KEY2   = 5'b00100,
    LK_KEY3   = 5'b01000,
    LK_LOCKED = 5'b10000
  } lock_state_e;

  lock_state_e state_q, state_d;
  logic [15:0] mask_q, mask_d;
  logic        mask_match;

  assign mask_match = (cmd_i.mask == mask_q);

  // Sequence steps; until the port is locked, any write that does not continue the sequence restarts it.
  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    if (cmd_i.wr && (state_q != LK_LOCKED)) begin
      if ((state_q == LK_KEY1) && !cmd_i.key && mask_match) begin
        state_d = LK_KEY2;
      end else if ((state_q == LK_KEY2) && cmd_i.key && mask_match) begin
        state_d = LK_KEY3;
      end else begin
        mask_d  = cmd_i.mask;
        state_d = cmd_i.key ? LK_KEY1 : LK_IDLE;
      end
    end else if (cmd_i.rd && (state_q == LK_KEY3)) begin
      state_d = LK_LOCKED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LK_IDLE;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
    end
  end

  assign stat_o.mask        = mask_q;
  assign stat_o.locked      = (state_q == LK_LOCKED);
  assign stat_o.locked_next = (state_d == LK_LOCKED);

endmodule

`default_nettype wire

/* design/gpio_port_register_block.sv */
// Channel    Handshake               Payload  Direction
// request    start high, busy low    req_i    in
// result     valid_o strobe          rsp_o    out
//
// One transaction is accepted in every cycle; busy stays low.
// A transaction is registered on acceptance and its result is registered in
// the following cycle, from which valid_o and rsp_o are driven.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset clears all port registers and the lock; no clearing pass is needed.
`default_nettype none
`include "gpio_port_register_block_defines.svh"

module gpio_port_register_block
  import gprb_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      valid_o,
  output rsp_t      rsp_o
);

  // Implemented-pin masks.
  localparam logic [15:0] PinMask  = 16'((32'd1 << PIN_COUNT) - 32'd1);
  localparam logic [31:0] Impl2    = spread2(PinMask);
  localparam logic [31:0] Impl4Lo  = spread4(PinMask[7:0]);
  localparam logic [31:0] Impl4Hi  = spread4(PinMask[15:8]);

  // Input stage.
  logic        req_valid_q;
  req_t        req_q;

  // Port registers.
  logic [31:0] mode_q, mode_d;
  logic [15:0] type_q, type_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] pull_q, pull_d;
  logic [15:0] out_q, out_d;
  logic [31:0] af_lo_q, af_lo_d;
  logic [31:0] af_hi_q, af_hi_d;

  // Result stage.
  logic        rsp_valid_q;
  rsp_t        rsp_q, rsp_d;

  lock_cmd_t   lock_cmd;
  lock_stat_t  lock_stat;
  logic [15:0] locked_pins;
  logic [31:0] locked2;
  logic        is_write;
  logic        is_read;
  logic [15:0] set_pins;
  logic [15:0] clr_pins;

  assign busy = 1'b0;

  // Register the accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign is_write    = req_valid_q && (req_q.action == ACT_WRITE);
  assign is_read     = req_valid_q && (req_q.action == ACT_READ);
  assign locked_pins = lock_stat.locked ? lock_stat.mask : 16'h0000;
  assign locked2     = spread2(locked_pins);
  assign set_pins    = req_q.write_data[15:0] & PinMask;
  assign clr_pins    = req_q.write_data[31:16] & PinMask;

  // Lock sequencer command.
  assign lock_cmd.wr   = is_write && (req_q.reg_index == REG_LOCK);
  assign lock_cmd.rd   = is_read && (req_q.reg_index == REG_LOCK);
  assign lock_cmd.key  = req_q.write_data[LockKeyBit];
  assign lock_cmd.mask = req_q.write_data[15:0] & PinMask;

  gprb_lock u_lock (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lock_cmd),
    .stat_o (lock_stat)
  );

  // Register updates and read mux.
  always_comb begin
    mode_d  = mode_q;
    type_d  = type_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    out_d   = out_q;
    af_lo_d = af_lo_q;
    af_hi_d = af_hi_q;
    rsp_d   = '0;
    if (is_write) begin
      case (req_q.reg_index)
        REG_MODE: begin
          mode_d = guarded_write(mode_q, req_q.write_data, Impl2, locked2);
          rsp_d.write_blocked = guarded_hit(mode_q, req_q.write_data, Impl2, locked2);
        end
        REG_TYPE: begin
          type_d = 16'(guarded_write({16'h0000, type_q}, req_q.write_data,
                                     {16'h0000, PinMask}, {16'h0000, locked_pins}));
          rsp_d.write_blocked = guarded_hit({16'h0000, type_q}, req_q.write_data,
                                            {16'h0000, PinMask}, {16'h0000, locked_pins});
        end
        REG_SPEED: begin
          speed_d = guarded_write(speed_q, req_q.write_data, Impl2, locked2);
          rsp_d.write_blocked = guarded_hit(speed_q, req_q.write_data, Impl2, locked2);
        end
        REG_PULL: begin
          pull_d = guarded_write(pull_q, req_q.write_data, Impl2, locked2);
          rsp_d.write_blocked = guarded_hit(pull_q, req_q.write_data, Impl2, locked2);
        end
        REG_OUTPUT: begin
          out_d = req_q.write_data[15:0] & PinMask;
        end
        REG_SETRESET: begin
          out_d = ((out_q & ~clr_pins) | set_pins) & PinMask;
        end
        REG_AFLOW: begin
          af_lo_d = guarded_write(af_lo_q, req_q.write_data, Impl4Lo,
                                  spread4(locked_pins[7:0]));
          rsp_d.write_blocked = guarded_hit(af_lo_q, req_q.write_data, Impl4Lo,
                                            spread4(locked_pins[7:0]));
        end
        REG_AFHIGH: begin
          af_hi_d = guarded_write(af_hi_q, req_q.write_data, Impl4Hi,
                                  spread4(locked_pins[15:8]));
          rsp_d.write_blocked = guarded_hit(af_hi_q, req_q.write_data, Impl4Hi,
                                            spread4(locked_pins[15:8]));
        end
        default: begin
        end
      endcase
    end else if (is_read) begin
      case (req_q.reg_index)
        REG_MODE:   rsp_d.read_data = mode_q;
        REG_TYPE:   rsp_d.read_data = {16'h0000, type_q};
        REG_SPEED:  rsp_d.read_data = speed_q;
        REG_PULL:   rsp_d.read_data = pull_q;
        REG_INPUT:  rsp_d.read_data = {16'h0000, req_q.pin_levels & PinMask};
        REG_OUTPUT: rsp_d.read_data = {16'h0000, out_q};
        REG_LOCK:   rsp_d.read_data = {15'h0000, lock_stat.locked_next, lock_stat.mask};
        REG_AFLOW:  rsp_d.read_data = af_lo_q;
        REG_AFHIGH: rsp_d.read_data = af_hi_q;
        default:    rsp_d.read_data = '0;
      endcase
    end
    rsp_d.output_levels = out_d;
    rsp_d.lock_active   = lock_stat.locked_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      type_q      <= '0;
      speed_q     <= '0;
      pull_q      <= '0;
      out_q       <= '0;
      af_lo_q     <= '0;
      af_hi_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      type_q      <= type_d;
      speed_q     <= speed_d;
      pull_q      <= pull_d;
      out_q       <= out_d;
      af_lo_q     <= af_lo_d;
      af_hi_q     <= af_hi_d;
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_valid_q;
  assign rsp_o   = rsp_q;

  // Every accepted transaction produces a result, after the input and result registers.
  `GPRB_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, start && !busy, ##1 valid_o)
  // Once locked, the port stays locked until reset.
  `GPRB_ASSERT_NEXT(a_lock_sticky, clk_i, rst_ni, lock_stat.locked, lock_stat.locked)
  // A blocked write can only happen on a locked port.
  `GPRB_ASSERT_IMPL(a_blocked_needs_lock, clk_i, rst_ni,
                    valid_o && rsp_o.write_blocked, rsp_o.lock_active)
  // Unimplemented pins never drive an output level.
  `GPRB_ASSERT(a_out_masked, clk_i, rst_ni, (out_q & ~PinMask) == 16'h0000)

endmodule

`default_nettype wire
